// ===== rtl/cage_pkg.sv =====
// Shared types and constants for the CIP advection grid engine.
// No dependencies; imported by cage_mulk and cip_advection_grid_engine.
package cage_pkg;

   // item field widths fixed by the interface
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;

   // Courant number: unsigned Q0.16, one bit of headroom for 1.0
   localparam int                K_W    = 17;
   localparam int                K_FRAC = 16;
   localparam int                K_HALF = 32768;
   localparam logic [K_W-1:0]    K_ONE  = 17'd65536;

   // configuration registers
   localparam int                CSR_ADDR_W = 2;
   localparam int                CSR_DATA_W = 17;
   localparam int                GRID_W     = 11;
   localparam int                STEPS_W    = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_COURANT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEPS   = 2'd2;
   localparam logic [K_W-1:0]        COURANT_RST = 17'd26214;
   localparam logic [GRID_W-1:0]     GRID_RST    = 11'd64;
   localparam logic [STEPS_W-1:0]    STEPS_RST   = 16'd160;

   // command and status codes
   localparam logic [MODE_W-1:0]   MODE_WRITE   = 2'd0;
   localparam logic [MODE_W-1:0]   MODE_ADVANCE = 2'd1;
   localparam logic [MODE_W-1:0]   MODE_READ    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_PREP,
      ST_LEFT,
      ST_LOAD,
      ST_MUL_B,
      ST_MUL_A,
      ST_MUL_G,
      ST_MUL_3B,
      ST_MUL_2A,
      ST_STORE,
      ST_DONE
   } cage_state_type;

endpackage

// ===== rtl/cage_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cage_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cage_mulk.sv =====
// Shared Courant multiplier: y = round(x * k / 2^16), halves toward +inf.
// Depends on cage_pkg for the fixed-point format of k.
module cage_mulk #(
   parameter int XW = 32
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [XW-1:0]       x,
   input  logic [cage_pkg::K_W-1:0]   k,
   output logic signed [XW-1:0]       y
);
   import cage_pkg::*;

   localparam int PW = XW + K_W + 1;

   logic signed [PW-1:0] x_ext;
   logic signed [PW-1:0] k_ext;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rnd;
   logic signed [XW-1:0] y_in;
   logic signed [XW-1:0] y_ff;

   always_comb begin
      x_ext = PW'(x);
      k_ext = signed'(PW'(k));
      prod  = x_ext * k_ext;
      // floor((x*k + half) / 2^16) on the full product is exact rounding
      rnd   = prod + PW'(K_HALF);
      y_in  = rnd[K_FRAC +: XW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// ===== rtl/cip_advection_grid_engine.sv =====
// CIP upwind advection engine on a periodic 1D grid of values and scaled slopes.
// A write (tuser 0), an advance on an empty grid or with a zero step count, and any item
// rejected for range or unused mode present their result in the cycle after they are accepted;
// a read (tuser 2) answers once the RAM read data is registered. An advance (tuser 1)
// sweeps step_count times over n = min(grid_size, GRID_DEPTH) points: each point is one
// RAM read, five passes through the single Courant multiplier and one write-back, and each
// step starts by fetching the last point as the left neighbor of point 0. No new item is
// taken until the current one is finished and its result register is free. Depends on
// cage_pkg, cage_ram and cage_mulk.
module cip_advection_grid_engine #(
   parameter int GRID_DEPTH   = 1024,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // index, value_in, slope_in (low to high), zero padded
   input  logic [((cage_pkg::INDEX_W+2*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic [cage_pkg::MODE_W-1:0]                req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // value_out, slope_out (low to high), zero padded
   output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // status
   output logic [cage_pkg::STATUS_W-1:0]              rsp_tuser,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [cage_pkg::CSR_ADDR_W-1:0]            csr_index,
   input  logic [cage_pkg::CSR_DATA_W-1:0]            csr_data
);
   import cage_pkg::*;

   localparam int W      = SAMPLE_WIDTH;
   localparam int IW     = SAMPLE_WIDTH + 8;
   localparam int AW     = $clog2(GRID_DEPTH);
   localparam int NW     = $clog2(GRID_DEPTH + 1);
   localparam int RSP_DW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

   localparam logic signed [IW-1:0] S_MAX = {{(IW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [IW-1:0] S_MIN = {{(IW-W+1){1'b1}}, {(W-1){1'b0}}};

   // configuration
   logic [K_W-1:0]     courant_ff;
   logic [GRID_W-1:0]  grid_ff;
   logic [STEPS_W-1:0] steps_ff;

   // control
   cage_state_type     state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic signed [W-1:0] value_out_ff, value_out_in;
   logic signed [W-1:0] slope_out_ff, slope_out_in;
   logic               sat_ff, sat_in;
   logic [AW-1:0]      pt_ff, pt_in;
   logic [STEPS_W-1:0] step_ff, step_in;

   // sweep datapath
   logic signed [W-1:0]  left_u_ff, left_u_in;
   logic signed [W-1:0]  left_g_ff, left_g_in;
   logic signed [W-1:0]  u1_ff, u1_in;
   logic signed [W-1:0]  g1_ff, g1_in;
   logic signed [IW-1:0] a_ff, a_in;
   logic signed [IW-1:0] b_ff, b_in;
   logic signed [IW-1:0] t_ff, t_in;

   // request fields
   logic [INDEX_W-1:0]  req_index;
   logic [W-1:0]        req_value;
   logic [W-1:0]        req_slope;
   logic                req_fire;
   logic                rsp_free;

   // derived configuration
   logic [16:0]         grid_wide;
   logic [NW-1:0]       n_cur;
   logic [NW-1:0]       n_m1;
   logic [K_W-1:0]      k_cur;
   logic                idx_ok;
   logic                last_pt;

   // RAM and multiplier hookup
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [2*W-1:0]      ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [2*W-1:0]      ram_rd_data;
   logic signed [W-1:0] rd_u;
   logic signed [W-1:0] rd_g;
   logic                mul_en;
   logic signed [IW-1:0] mul_x;
   logic signed [IW-1:0] mul_y;

   // point update terms
   logic signed [IW-1:0] d_cur;
   logic signed [IW-1:0] sum_u;
   logic signed [IW-1:0] sum_g;
   logic signed [W-1:0]  new_u;
   logic signed [W-1:0]  new_g;
   logic                 sat_u;
   logic                 sat_g;

   cage_ram #(
      .WIDTH (2 * W),
      .DEPTH (GRID_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cage_mulk #(
      .XW (IW)
   ) u_mulk (
      .clock (clock),
      .en    (mul_en),
      .x     (mul_x),
      .k     (k_cur),
      .y     (mul_y)
   );

   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_value = req_tdata[INDEX_W +: W];
   assign req_slope = req_tdata[INDEX_W+W +: W];
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({slope_out_ff, value_out_ff});
   assign rsp_tuser  = status_ff;
   assign csr_ready  = 1'b1;

   assign grid_wide = 17'(grid_ff);
   assign n_cur     = (grid_wide > 17'(GRID_DEPTH)) ? NW'(GRID_DEPTH) : NW'(grid_ff);
   assign n_m1      = n_cur - NW'(1);
   assign k_cur     = (courant_ff > K_ONE) ? K_ONE : courant_ff;
   assign idx_ok    = 17'(req_index) < 17'(n_cur);
   assign last_pt   = (pt_ff == n_m1[AW-1:0]);

   assign rd_u = ram_rd_data[W-1:0];
   assign rd_g = ram_rd_data[2*W-1:W];

   // D, A and B from the fetched point and its left neighbor
   always_comb begin
      d_cur = IW'(rd_u) - IW'(left_u_ff);
      a_in  = (IW'(rd_g) <<< 1) + IW'(left_g_ff) - ((d_cur <<< 1) + d_cur);
      b_in  = IW'(rd_g) + IW'(left_g_ff) - (d_cur <<< 1);
   end

   // final update with saturation to the sample range
   always_comb begin
      sum_u = IW'(u1_ff) + t_ff;
      sum_g = IW'(g1_ff) + mul_y;
      sat_u = (sum_u > S_MAX) || (sum_u < S_MIN);
      sat_g = (sum_g > S_MAX) || (sum_g < S_MIN);
      if (sum_u > S_MAX) begin
         new_u = S_MAX[W-1:0];
      end else if (sum_u < S_MIN) begin
         new_u = S_MIN[W-1:0];
      end else begin
         new_u = sum_u[W-1:0];
      end
      if (sum_g > S_MAX) begin
         new_g = S_MAX[W-1:0];
      end else if (sum_g < S_MIN) begin
         new_g = S_MIN[W-1:0];
      end else begin
         new_g = sum_g[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         courant_ff <= COURANT_RST;
         grid_ff    <= GRID_RST;
         steps_ff   <= STEPS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COURANT: courant_ff <= csr_data[K_W-1:0];
            CSR_GRID:    grid_ff    <= csr_data[GRID_W-1:0];
            CSR_STEPS:   steps_ff   <= csr_data[STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
         left_u_ff    <= '0;
         left_g_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sat_ff       <= sat_in;
         left_u_ff    <= left_u_in;
         left_g_ff    <= left_g_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      value_out_ff <= value_out_in;
      slope_out_ff <= slope_out_in;
      pt_ff        <= pt_in;
      step_ff      <= step_in;
      u1_ff        <= u1_in;
      g1_ff        <= g1_in;
      a_ff         <= (state_ff == ST_LOAD) ? a_in : a_ff;
      b_ff         <= (state_ff == ST_LOAD) ? b_in : b_ff;
      t_ff         <= t_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      value_out_in = value_out_ff;
      slope_out_in = slope_out_ff;
      sat_in       = sat_ff;
      pt_in        = pt_ff;
      step_in      = step_ff;
      left_u_in    = left_u_ff;
      left_g_in    = left_g_ff;
      u1_in        = u1_ff;
      g1_in        = g1_ff;
      t_in         = t_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pt_ff;
      ram_wr_data  = {new_g, new_u};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = pt_ff;
      mul_en       = 1'b0;
      mul_x        = '0;

      case (state_ff)
         ST_IDLE: begin
            ram_wr_addr = AW'(req_index);
            ram_wr_data = {req_slope, req_value};
            ram_rd_addr = AW'(req_index);
            if (req_fire) begin
               value_out_in = '0;
               slope_out_in = '0;
               status_in    = STATUS_OK;
               case (req_tuser)
                  MODE_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (idx_ok) begin
                        ram_wr_en = 1'b1;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  MODE_READ: begin
                     if (idx_ok) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                        status_in    = STATUS_RANGE;
                     end
                  end
                  MODE_ADVANCE: begin
                     sat_in = 1'b0;
                     if ((n_cur == '0) || (steps_ff == '0)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        step_in  = '0;
                        state_in = ST_PREP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               value_out_in = rd_u;
               slope_out_in = rd_g;
               status_in    = STATUS_OK;
               state_in     = ST_IDLE;
            end
         end
         ST_PREP: begin
            // last point is the left neighbor of point 0
            ram_rd_en   = 1'b1;
            ram_rd_addr = n_m1[AW-1:0];
            pt_in       = '0;
            state_in    = ST_LEFT;
         end
         ST_LEFT: begin
            left_u_in = rd_u;
            left_g_in = rd_g;
            ram_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            u1_in    = rd_u;
            g1_in    = rd_g;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            mul_en   = 1'b1;
            mul_x    = b_ff;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            mul_en   = 1'b1;
            mul_x    = a_ff - mul_y;
            state_in = ST_MUL_G;
         end
         ST_MUL_G: begin
            mul_en   = 1'b1;
            mul_x    = mul_y - IW'(g1_ff);
            state_in = ST_MUL_3B;
         end
         ST_MUL_3B: begin
            t_in     = mul_y;
            mul_en   = 1'b1;
            mul_x    = (b_ff <<< 1) + b_ff;
            state_in = ST_MUL_2A;
         end
         ST_MUL_2A: begin
            mul_en   = 1'b1;
            mul_x    = mul_y - (a_ff <<< 1);
            state_in = ST_STORE;
         end
         ST_STORE: begin
            ram_wr_en = 1'b1;
            sat_in    = sat_ff || sat_u || sat_g;
            left_u_in = u1_ff;
            left_g_in = g1_ff;
            if (last_pt) begin
               step_in = step_ff + STEPS_W'(1);
               if ((step_ff + STEPS_W'(1)) == steps_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PREP;
               end
            end else begin
               pt_in       = pt_ff + AW'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = pt_ff + AW'(1);
               state_in    = ST_LOAD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               value_out_in = '0;
               slope_out_in = '0;
               status_in    = sat_ff ? STATUS_SAT : STATUS_OK;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // point counter never runs past the active grid
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |-> (NW'(pt_ff) < n_cur))
      else $error("sweep point beyond grid size");

   // write-back only follows the last multiplier pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |-> ($past(state_ff) == ST_MUL_2A))
      else $error("store without full update sequence");

   // a result appears only from an idle accept, a read or the end of an advance
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(req_fire) || ($past(state_ff) == ST_READ) ||
                             ($past(state_ff) == ST_DONE)))
      else $error("result without a source");

   // step counter stays below the programmed count during a sweep
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (step_ff < steps_ff))
      else $error("step counter overran step_count");

   // no RAM write while the multiplier sequence is running
   assert property (@(posedge clock) disable iff (reset)
      mul_en |-> !ram_wr_en)
      else $error("store write during multiply");

endmodule
